@@ rtl/bfd_pkg.sv @@
package bfd_pkg;

  // fixed field widths
  localparam int DIM_W      = 7;
  localparam int STEP_W     = 20;
  localparam int BIAS_W     = 9;
  localparam int ADDR_W     = 12;
  localparam int PIX_W      = 32;
  localparam int COORD_W    = 10;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;
  localparam int STORE_DEPTH = 1 << ADDR_W;
  localparam int CH_MAX     = 255;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_X_STEP     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_STEP     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BIAS       = 3'd4;

  // request codes
  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_FILTER = 1'b1;

  typedef struct packed {
    logic start;   // capture a filter request, clear the sums
    logic write;   // store one source pixel
    logic setup;   // register origin, window and shift
    logic issue;   // read one window pixel
    logic finish;  // load the output register
  } bfd_cmd_t;

  typedef struct packed {
    logic empty;   // window has no pixels
    logic last;    // current read is the last of the window
  } bfd_status_t;

endpackage

@@ rtl/bfd_datapath.sv @@
module bfd_datapath #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64,
  parameter int MAX_STEP   = 8,
  parameter int FRAC_BITS  = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  bfd_pkg::bfd_cmd_t                  cmd_i,
  output bfd_pkg::bfd_status_t               status_o,
  input  logic [bfd_pkg::DIM_W-1:0]          src_width_i,
  input  logic [bfd_pkg::DIM_W-1:0]          src_height_i,
  input  logic [bfd_pkg::STEP_W-1:0]         x_step_i,
  input  logic [bfd_pkg::STEP_W-1:0]         y_step_i,
  input  logic signed [bfd_pkg::BIAS_W-1:0]  bias_i,
  input  logic [bfd_pkg::ADDR_W-1:0]         load_address_i,
  input  logic [bfd_pkg::PIX_W-1:0]          pixel_argb_i,
  input  logic [bfd_pkg::COORD_W-1:0]        dest_x_i,
  input  logic [bfd_pkg::COORD_W-1:0]        dest_y_i,
  output logic [bfd_pkg::PIX_W-1:0]          filtered_argb_o
);

  localparam int SIDE_W = $clog2(MAX_STEP + 1);
  localparam int PR_W   = 2 * SIDE_W;
  localparam int SH_W   = $clog2(PR_W);
  localparam int PROD_W = bfd_pkg::COORD_W + bfd_pkg::STEP_W;
  localparam int OX_W   = PROD_W - FRAC_BITS;
  localparam int CX_W   = OX_W + 1;
  localparam int SUM_W  = 8 + PR_W;
  localparam int LIN_W  = 2 * bfd_pkg::DIM_W + 1;
  localparam int DW     = bfd_pkg::DIM_W;

  function automatic logic [SIDE_W-1:0] side_of(input logic [bfd_pkg::STEP_W-1:0] step);
    logic [31:0] rnd;
    logic [31:0] raw;
    rnd = 32'(step) + (32'(1) << FRAC_BITS) - 32'(1);
    raw = rnd >> FRAC_BITS;
    if (raw > 32'(MAX_STEP)) begin
      side_of = SIDE_W'(MAX_STEP);
    end else begin
      side_of = raw[SIDE_W-1:0];
    end
  endfunction

  function automatic logic [DW-1:0] clamp_dim(input logic [DW-1:0] v, input int maxv);
    if (v == '0) begin
      clamp_dim = DW'(1);
    end else if (32'(v) > 32'(maxv)) begin
      clamp_dim = DW'(maxv);
    end else begin
      clamp_dim = v;
    end
  endfunction

  function automatic logic [7:0] finish_ch(input logic [SUM_W-1:0] s,
                                           input logic [SH_W-1:0] sh,
                                           input logic signed [bfd_pkg::BIAS_W-1:0] b);
    logic [SUM_W-1:0]        t;
    logic signed [SUM_W+1:0] v;
    t = s >> sh;
    v = $signed({2'b00, t}) + $signed({{(SUM_W + 2 - bfd_pkg::BIAS_W){b[bfd_pkg::BIAS_W-1]}}, b});
    if (v < 0) begin
      finish_ch = 8'd0;
    end else if (v > $signed((SUM_W+2)'(bfd_pkg::CH_MAX))) begin
      finish_ch = 8'(bfd_pkg::CH_MAX);
    end else begin
      finish_ch = v[7:0];
    end
  endfunction

  logic [bfd_pkg::PIX_W-1:0] store_q [bfd_pkg::STORE_DEPTH];

  logic [bfd_pkg::COORD_W-1:0] dx_q, dy_q;
  logic [OX_W-1:0]             ox_q, oy_q;
  logic [SIDE_W-1:0]           fx_q, fy_q;
  logic [SH_W-1:0]             sh_q;
  logic [DW-1:0]               w_q, wm1_q, hm1_q;
  logic [SIDE_W-1:0]           cnt_x_q, cnt_y_q;
  logic                        rd_vld_q;
  logic [bfd_pkg::PIX_W-1:0]   rdata_q;
  logic [SUM_W-1:0]            sum_a_q, sum_r_q, sum_g_q, sum_b_q;
  logic [bfd_pkg::PIX_W-1:0]   out_q;

  // setup values
  logic [SIDE_W-1:0] fx_d, fy_d;
  logic [PR_W-1:0]   area;
  logic [SH_W-1:0]   sh_d;
  logic [PROD_W-1:0] prod_x, prod_y;
  logic [DW-1:0]     w_d, h_d;

  always_comb begin
    fx_d   = side_of(x_step_i);
    fy_d   = side_of(y_step_i);
    area   = PR_W'(fx_d) * PR_W'(fy_d);
    sh_d   = '0;
    for (int i = 1; i < PR_W; i++) begin
      if (area[i]) begin
        sh_d = SH_W'(i);
      end
    end
    prod_x = PROD_W'(dx_q) * PROD_W'(x_step_i);
    prod_y = PROD_W'(dy_q) * PROD_W'(y_step_i);
    w_d    = clamp_dim(src_width_i, MAX_WIDTH);
    h_d    = clamp_dim(src_height_i, MAX_HEIGHT);
  end

  // window walk: clamp to last column and row, then row-major address
  logic [CX_W-1:0]           cxs, cys;
  logic [DW-1:0]             cx, cy;
  logic [LIN_W-1:0]          lin;
  logic [bfd_pkg::ADDR_W-1:0] rd_addr;
  logic                      x_wrap;

  always_comb begin
    cxs     = CX_W'(ox_q) + CX_W'(cnt_x_q);
    cys     = CX_W'(oy_q) + CX_W'(cnt_y_q);
    cx      = (cxs > CX_W'(wm1_q)) ? wm1_q : cxs[DW-1:0];
    cy      = (cys > CX_W'(hm1_q)) ? hm1_q : cys[DW-1:0];
    lin     = LIN_W'(cy) * LIN_W'(w_q) + LIN_W'(cx);
    rd_addr = lin[bfd_pkg::ADDR_W-1:0];
    x_wrap  = (cnt_y_q == fy_q - SIDE_W'(1));
  end

  assign status_o.empty = (fx_q == '0) || (fy_q == '0);
  assign status_o.last  = x_wrap && (cnt_x_q == fx_q - SIDE_W'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_x_q  <= '0;
      cnt_y_q  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.issue;
      if (cmd_i.setup) begin
        cnt_x_q <= '0;
        cnt_y_q <= '0;
      end else if (cmd_i.issue) begin
        if (x_wrap) begin
          cnt_y_q <= '0;
          cnt_x_q <= cnt_x_q + SIDE_W'(1);
        end else begin
          cnt_y_q <= cnt_y_q + SIDE_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.write) begin
      store_q[load_address_i] <= pixel_argb_i;
    end
    if (cmd_i.issue) begin
      rdata_q <= store_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      dx_q    <= dest_x_i;
      dy_q    <= dest_y_i;
      sum_a_q <= '0;
      sum_r_q <= '0;
      sum_g_q <= '0;
      sum_b_q <= '0;
    end else if (rd_vld_q) begin
      sum_a_q <= sum_a_q + SUM_W'(rdata_q[31:24]);
      sum_r_q <= sum_r_q + SUM_W'(rdata_q[23:16]);
      sum_g_q <= sum_g_q + SUM_W'(rdata_q[15:8]);
      sum_b_q <= sum_b_q + SUM_W'(rdata_q[7:0]);
    end
    if (cmd_i.setup) begin
      ox_q  <= prod_x[PROD_W-1:FRAC_BITS];
      oy_q  <= prod_y[PROD_W-1:FRAC_BITS];
      fx_q  <= fx_d;
      fy_q  <= fy_d;
      sh_q  <= sh_d;
      w_q   <= w_d;
      wm1_q <= w_d - DW'(1);
      hm1_q <= h_d - DW'(1);
    end
    if (cmd_i.finish) begin
      out_q <= {finish_ch(sum_a_q, sh_q, bias_i), finish_ch(sum_r_q, sh_q, bias_i),
                finish_ch(sum_g_q, sh_q, bias_i), finish_ch(sum_b_q, sh_q, bias_i)};
    end
  end

  assign filtered_argb_o = out_q;

endmodule

@@ rtl/bfd_ctrl.sv @@
module bfd_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 req_type_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output bfd_pkg::bfd_cmd_t    cmd_o,
  input  bfd_pkg::bfd_status_t status_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SETUP,
    S_RUN,
    S_WAIT,
    S_FINISH
  } state_e;

  state_e state_q, state_d;
  logic   stall_q;
  logic   out_valid_q;
  logic   accept;
  logic   out_free;

  assign accept   = in_valid_i && !stall_q;
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (req_type_i == bfd_pkg::REQ_FILTER) begin
            cmd_o.start = 1'b1;
            state_d     = S_SETUP;
          end else begin
            cmd_o.write = 1'b1;
          end
        end
      end
      S_SETUP: begin
        cmd_o.setup = 1'b1;
        state_d     = S_RUN;
      end
      S_RUN: begin
        cmd_o.issue = !status_i.empty;
        if (status_i.empty || status_i.last) begin
          state_d = S_WAIT;
        end
      end
      S_WAIT: begin
        state_d = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      stall_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      stall_q <= (state_d != S_IDLE);
      if (cmd_o.finish) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign in_stall_o  = stall_q;
  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  a_busy_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> in_stall_o)
    else $error("input not stalled while a request is in progress");

  a_filter_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && req_type_i == bfd_pkg::REQ_FILTER) |=> (state_q == S_SETUP))
    else $error("accepted filter request did not start setup");

  a_result_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_FINISH))
    else $error("result raised outside the finish step");

  a_last_read_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.issue && status_i.last) |=> (state_q == S_WAIT && !cmd_o.issue))
    else $error("window walk did not stop after its last read");
`endif

endmodule

@@ rtl/box_filter_downscaler.sv @@
// Box-filter downscaler for ARGB8888 images. Source pixels are loaded one
// word per transfer (req_type 0) into a 4096-word store, which needs no
// clearing after reset; reading a never-written entry gives an undefined
// pixel. A filter request (req_type 1) returns one pixel averaged over a
// ceil(step) by ceil(step) window at floor(dest*step), clamped to the last
// column and row, shifted by floor(log2(window size)), biased and clamped
// to 0..255. A filter request reads its window one pixel at a time (window
// sides fx, fy up to MAX_STEP), since the store has a single read port and
// each window pixel costs one read. Requests are handled one at a time; a
// finished result sits in an output register, so the next transfer is taken
// while it waits. Configuration must be written only while the block is idle;
// the block itself does not enforce it.
module box_filter_downscaler #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64,
  parameter int MAX_STEP   = 8,
  parameter int FRAC_BITS  = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration write channel
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [bfd_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [bfd_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  // request channel
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              req_type_i,
  input  logic [bfd_pkg::ADDR_W-1:0]        load_address_i,
  input  logic [bfd_pkg::PIX_W-1:0]         pixel_argb_i,
  input  logic [bfd_pkg::COORD_W-1:0]       dest_x_i,
  input  logic [bfd_pkg::COORD_W-1:0]       dest_y_i,
  // result channel
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [bfd_pkg::PIX_W-1:0]         filtered_argb_o
);

  // configuration registers, reset to a 64 by 64 image at unit step
  logic [bfd_pkg::DIM_W-1:0]         src_width_q, src_height_q;
  logic [bfd_pkg::STEP_W-1:0]        x_step_q, y_step_q;
  logic signed [bfd_pkg::BIAS_W-1:0] bias_q;

  bfd_pkg::bfd_cmd_t    cmd;
  bfd_pkg::bfd_status_t status;

  // writes are always taken
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_width_q  <= bfd_pkg::DIM_W'(64);
      src_height_q <= bfd_pkg::DIM_W'(64);
      x_step_q     <= bfd_pkg::STEP_W'(1) << FRAC_BITS;
      y_step_q     <= bfd_pkg::STEP_W'(1) << FRAC_BITS;
      bias_q       <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        bfd_pkg::CFG_SRC_WIDTH:  src_width_q  <= cfg_data_i[bfd_pkg::DIM_W-1:0];
        bfd_pkg::CFG_SRC_HEIGHT: src_height_q <= cfg_data_i[bfd_pkg::DIM_W-1:0];
        bfd_pkg::CFG_X_STEP:     x_step_q     <= cfg_data_i[bfd_pkg::STEP_W-1:0];
        bfd_pkg::CFG_Y_STEP:     y_step_q     <= cfg_data_i[bfd_pkg::STEP_W-1:0];
        bfd_pkg::CFG_BIAS:       bias_q       <= $signed(cfg_data_i[bfd_pkg::BIAS_W-1:0]);
        default: begin
          // unknown index: write ignored
        end
      endcase
    end
  end

  // sequencer: accept, setup, window walk, drain, finish
  bfd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .req_type_i  (req_type_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  // store, address generation, channel sums and output register
  bfd_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_STEP   (MAX_STEP),
    .FRAC_BITS  (FRAC_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .src_width_i     (src_width_q),
    .src_height_i    (src_height_q),
    .x_step_i        (x_step_q),
    .y_step_i        (y_step_q),
    .bias_i          (bias_q),
    .load_address_i  (load_address_i),
    .pixel_argb_i    (pixel_argb_i),
    .dest_x_i        (dest_x_i),
    .dest_y_i        (dest_y_i),
    .filtered_argb_o (filtered_argb_o)
  );

endmodule

@@ tb/sv/bfd_pixel_checker.sv @@
module bfd_pixel_checker
  import bfd_pkg::*;
#(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64,
  parameter int MAX_STEP   = 8,
  parameter int FRAC_BITS  = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  logic                  req_type_i,
  input  logic [ADDR_W-1:0]     load_address_i,
  input  logic [PIX_W-1:0]      pixel_argb_i,
  input  logic [COORD_W-1:0]    dest_x_i,
  input  logic [COORD_W-1:0]    dest_y_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  logic [PIX_W-1:0]      filtered_argb_i,
  output int                    fail_count_o,
  output int                    pending_o
);

  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } argb_t;

  logic [PIX_W-1:0]         image_copy [STORE_DEPTH];
  logic [DIM_W-1:0]         width_reg;
  logic [DIM_W-1:0]         height_reg;
  logic [STEP_W-1:0]        xstep_reg;
  logic [STEP_W-1:0]        ystep_reg;
  logic signed [BIAS_W-1:0] bias_reg;
  argb_t                    expected_pixels [$];
  argb_t                    oldest;

  function automatic int unsigned clamp_dim(logic [DIM_W-1:0] v, int unsigned maxv);
    if (v == '0) return 1;
    if (32'(v) > maxv) return maxv;
    return 32'(v);
  endfunction

  function automatic int unsigned window_side(logic [STEP_W-1:0] step);
    int unsigned side;
    side = (32'(step) + (32'd1 << FRAC_BITS) - 32'd1) >> FRAC_BITS;
    return (side > MAX_STEP) ? MAX_STEP : side;
  endfunction

  // sum over the clamped window, scale down, bias and saturate each channel
  function automatic argb_t box_average(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
    int unsigned w, h, ox, oy, fx, fy, cx, cy, cells, shift;
    int unsigned sum [4];
    int          level;
    logic [7:0]  chan [4];
    argb_t       p;
    w  = clamp_dim(width_reg, MAX_WIDTH);
    h  = clamp_dim(height_reg, MAX_HEIGHT);
    ox = (32'(x) * 32'(xstep_reg)) >> FRAC_BITS;
    oy = (32'(y) * 32'(ystep_reg)) >> FRAC_BITS;
    fx = window_side(xstep_reg);
    fy = window_side(ystep_reg);
    for (int i = 0; i < 4; i++) sum[i] = 0;
    for (int unsigned dx = 0; dx < fx; dx++) begin
      for (int unsigned dy = 0; dy < fy; dy++) begin
        cx = ox + dx;
        cy = oy + dy;
        if (cx > w - 1) cx = w - 1;
        if (cy > h - 1) cy = h - 1;
        p = image_copy[ADDR_W'(cy * w + cx)];
        sum[0] += p.alpha;
        sum[1] += p.red;
        sum[2] += p.green;
        sum[3] += p.blue;
      end
    end
    cells = fx * fy;
    shift = 0;
    while (cells > 1) begin
      cells >>= 1;
      shift++;
    end
    for (int i = 0; i < 4; i++) begin
      level = int'(sum[i] >> shift) + int'(bias_reg);
      if (level < 0) level = 0;
      if (level > CH_MAX) level = CH_MAX;
      chan[i] = 8'(level);
    end
    return {chan[0], chan[1], chan[2], chan[3]};
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_reg    <= DIM_W'(MAX_WIDTH);
      height_reg   <= DIM_W'(MAX_HEIGHT);
      xstep_reg    <= STEP_W'(1) << FRAC_BITS;
      ystep_reg    <= STEP_W'(1) << FRAC_BITS;
      bias_reg     <= '0;
      fail_count_o <= 0;
      pending_o    <= 0;
      expected_pixels.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_SRC_WIDTH:  width_reg  <= cfg_data_i[DIM_W-1:0];
          CFG_SRC_HEIGHT: height_reg <= cfg_data_i[DIM_W-1:0];
          CFG_X_STEP:     xstep_reg  <= cfg_data_i[STEP_W-1:0];
          CFG_Y_STEP:     ystep_reg  <= cfg_data_i[STEP_W-1:0];
          CFG_BIAS:       bias_reg   <= cfg_data_i[BIAS_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        if (req_type_i == REQ_LOAD) begin
          image_copy[load_address_i] <= pixel_argb_i;
        end else begin
          expected_pixels.insert(expected_pixels.size(), box_average(dest_x_i, dest_y_i));
        end
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_pixels.size() == 0) begin
          $error("filtered_argb: unexpected result, expected none, got %h", filtered_argb_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          oldest = expected_pixels.pop_front();
          if (oldest != filtered_argb_i) begin
            $error("filtered_argb mismatch: expected %h, got %h", oldest, filtered_argb_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      pending_o <= expected_pixels.size();
    end
  end

endmodule

@@ tb/sv/tb_box_filter_downscaler.sv @@
module tb_box_filter_downscaler;
  import bfd_pkg::*;

  // block geometry, kept equal between the block and the checker
  localparam int MAX_W = 64;
  localparam int MAX_H = 64;
  localparam int MAX_SIDE = 8;
  localparam int FRAC = 16;

  // run shape
  localparam int LIMIT_CYCLES = 1_000_000;
  localparam int DRAIN_CYCLES = 80;   // covers the longest filter, an 8 by 8 window, plus margin
  localparam int ITEM_BUDGET  = 1750;
  localparam int SEGMENTS     = 8;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic                  req_type_i;
  logic [ADDR_W-1:0]     load_address_i;
  logic [PIX_W-1:0]      pixel_argb_i;
  logic [COORD_W-1:0]    dest_x_i;
  logic [COORD_W-1:0]    dest_y_i;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [PIX_W-1:0]      filtered_argb_o;

  int fail_count;
  int pending;
  int idle_pct    = 0;
  int stall_pct   = 0;
  int items_sent  = 0;
  int cycle_count = 0;

  // mirror of the register settings, used only to keep requests on written pixels
  logic [DIM_W-1:0]  cur_width;
  logic [DIM_W-1:0]  cur_height;
  logic [STEP_W-1:0] cur_xstep;
  logic [STEP_W-1:0] cur_ystep;
  bit                loaded [STORE_DEPTH];

  box_filter_downscaler #(
    .MAX_WIDTH  (MAX_W),
    .MAX_HEIGHT (MAX_H),
    .MAX_STEP   (MAX_SIDE),
    .FRAC_BITS  (FRAC)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .req_type_i      (req_type_i),
    .load_address_i  (load_address_i),
    .pixel_argb_i    (pixel_argb_i),
    .dest_x_i        (dest_x_i),
    .dest_y_i        (dest_y_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .filtered_argb_o (filtered_argb_o)
  );

  bfd_pixel_checker #(
    .MAX_WIDTH  (MAX_W),
    .MAX_HEIGHT (MAX_H),
    .MAX_STEP   (MAX_SIDE),
    .FRAC_BITS  (FRAC)
  ) pixel_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_i     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .req_type_i      (req_type_i),
    .load_address_i  (load_address_i),
    .pixel_argb_i    (pixel_argb_i),
    .dest_x_i        (dest_x_i),
    .dest_y_i        (dest_y_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .filtered_argb_i (filtered_argb_o),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // receiver back-pressure, redrawn every cycle
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // watchdog on the whole run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic int unsigned side_of(logic [STEP_W-1:0] s);
    int unsigned n;
    n = (32'(s) + (32'd1 << FRAC) - 32'd1) >> FRAC;
    return (n > MAX_SIDE) ? MAX_SIDE : n;
  endfunction

  // mostly random words, now and then saturated channels for the clamps
  function automatic logic [PIX_W-1:0] random_pixel();
    case ($urandom_range(7))
      0:       return '1;
      1:       return '0;
      default: return PIX_W'($urandom);
    endcase
  endfunction

  function automatic logic [COORD_W-1:0] pick_coord();
    return ($urandom_range(3) == 0) ? COORD_W'($urandom) : COORD_W'($urandom_range(15));
  endfunction

  function automatic logic [DIM_W-1:0] pick_dim();
    case ($urandom_range(7))
      0:       return DIM_W'($urandom);
      1:       return DIM_W'(MAX_W);
      default: return DIM_W'($urandom_range(1, 12));
    endcase
  endfunction

  // zero, full-range, exact 8.0, whole numbers, and mostly small fractional steps
  function automatic logic [STEP_W-1:0] pick_step();
    case ($urandom_range(9))
      0:       return '0;
      1:       return STEP_W'($urandom);
      2:       return STEP_W'(MAX_SIDE) << FRAC;
      3:       return STEP_W'($urandom_range(1, MAX_SIDE)) << FRAC;
      default: return STEP_W'($urandom_range(1, 3 << FRAC));
    endcase
  endfunction

  // one transfer on the request channel; valid stays high afterwards so that
  // back-to-back transfers need no gap
  task automatic push_item(logic kind, logic [ADDR_W-1:0] addr, logic [PIX_W-1:0] pix,
                           logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    req_type_i     = kind;
    load_address_i = addr;
    pixel_argb_i   = pix;
    dest_x_i       = x;
    dest_y_i       = y;
    in_valid_i     = 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
    items_sent++;
  endtask

  // load transfer; dest fields carry noise since the block ignores them
  task automatic load_pixel(logic [ADDR_W-1:0] addr, logic [PIX_W-1:0] pix);
    push_item(REQ_LOAD, addr, pix, COORD_W'($urandom), COORD_W'($urandom));
    loaded[addr] = 1'b1;
  endtask

  // filter transfer, preceded by loads of any window pixel not yet written
  task automatic filter_pixel(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
    int unsigned w, h, ox, oy, cx, cy;
    logic [ADDR_W-1:0] addr;
    w  = (cur_width == '0) ? 1 : ((cur_width > MAX_W) ? MAX_W : cur_width);
    h  = (cur_height == '0) ? 1 : ((cur_height > MAX_H) ? MAX_H : cur_height);
    ox = (32'(x) * 32'(cur_xstep)) >> FRAC;
    oy = (32'(y) * 32'(cur_ystep)) >> FRAC;
    for (int unsigned dx = 0; dx < side_of(cur_xstep); dx++) begin
      for (int unsigned dy = 0; dy < side_of(cur_ystep); dy++) begin
        cx   = (ox + dx > w - 1) ? w - 1 : ox + dx;
        cy   = (oy + dy > h - 1) ? h - 1 : oy + dy;
        addr = ADDR_W'(cy * w + cx);
        if (!loaded[addr]) load_pixel(addr, random_pixel());
      end
    end
    push_item(REQ_FILTER, ADDR_W'($urandom), PIX_W'($urandom), x, y);
  endtask

  // drop valid, let every result come back and the block settle
  task automatic go_idle();
    in_valid_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic set_up(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h, logic [STEP_W-1:0] xs,
                        logic [STEP_W-1:0] ys, logic [BIAS_W-1:0] b);
    go_idle();
    write_reg(CFG_SRC_WIDTH, CFG_DATA_W'(w));
    write_reg(CFG_SRC_HEIGHT, CFG_DATA_W'(h));
    write_reg(CFG_X_STEP, CFG_DATA_W'(xs));
    write_reg(CFG_Y_STEP, CFG_DATA_W'(ys));
    write_reg(CFG_BIAS, CFG_DATA_W'(b));
    cur_width  = w;
    cur_height = h;
    cur_xstep  = xs;
    cur_ystep  = ys;
  endtask

  initial begin
    int base;
    int target;
    rst_ni         = 1'b0;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = CFG_SRC_WIDTH;
    cfg_data_i     = '0;
    in_valid_i     = 1'b0;
    req_type_i     = REQ_LOAD;
    load_address_i = '0;
    pixel_argb_i   = '0;
    dest_x_i       = '0;
    dest_y_i       = '0;
    cur_width      = DIM_W'(MAX_W);
    cur_height     = DIM_W'(MAX_H);
    cur_xstep      = STEP_W'(1) << FRAC;
    cur_ystep      = STEP_W'(1) << FRAC;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    // settings straight out of reset: 64 by 64, unit steps, no bias
    load_pixel(ADDR_W'(0), '1);
    filter_pixel(COORD_W'(0), COORD_W'(0));
    load_pixel(ADDR_W'(STORE_DEPTH - 1), 32'hA55A_C33C);
    // far corner, origin well outside the image, clamps to the last pixel
    filter_pixel('1, '1);

    // 2 by 2 window over a 2 by 2 image, shift of two
    set_up(DIM_W'(2), DIM_W'(2), STEP_W'(2) << FRAC, STEP_W'(2) << FRAC, '0);
    filter_pixel(COORD_W'(0), COORD_W'(0));
    filter_pixel('1, COORD_W'(0));
    // largest and smallest bias drive every channel into the clamps
    set_up(DIM_W'(2), DIM_W'(2), STEP_W'(2) << FRAC, STEP_W'(2) << FRAC, BIAS_W'(255));
    filter_pixel(COORD_W'(1), COORD_W'(0));
    set_up(DIM_W'(2), DIM_W'(2), STEP_W'(2) << FRAC, STEP_W'(2) << FRAC, 9'h100);
    filter_pixel(COORD_W'(0), COORD_W'(1));
    // exact 8.0 steps: full 8 by 8 window, all reads clamped into the 2 by 2 image
    set_up(DIM_W'(2), DIM_W'(2), STEP_W'(MAX_SIDE) << FRAC, STEP_W'(MAX_SIDE) << FRAC, '0);
    filter_pixel(COORD_W'(0), COORD_W'(0));

    // zero step gives an empty window, so only the bias comes out
    set_up('1, '0, '0, STEP_W'(1) << FRAC, BIAS_W'(100));
    filter_pixel(COORD_W'(5), COORD_W'(5));
    // width above the maximum and zero height
    set_up('1, '0, STEP_W'(1) << FRAC, STEP_W'(1) << FRAC, '0);
    filter_pixel('1, COORD_W'(0));
    filter_pixel(COORD_W'(0), '1);
    // zero width, height above the maximum, oversized x step saturating the side
    set_up('0, '1, '1, STEP_W'(7) << (FRAC - 1), 9'h1F0);
    filter_pixel('1, '1);
    filter_pixel(COORD_W'(0), COORD_W'(0));

    // random segments, each with fresh settings and one of four idling patterns
    base = items_sent;
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      set_up(pick_dim(), pick_dim(), pick_step(), pick_step(), BIAS_W'($urandom));
      case (seg % 4)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct  = 86;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 86;
        end
        default: begin
          idle_pct  = 18;
          stall_pct = 18;
        end
      endcase
      target = base + (seg + 1) * ITEM_BUDGET / SEGMENTS;
      while (items_sent < target) begin
        // mostly filter requests on written pixels, the rest stray loads anywhere
        if ($urandom_range(9) < 3) begin
          load_pixel(ADDR_W'($urandom), random_pixel());
        end else begin
          filter_pixel(pick_coord(), pick_coord());
        end
      end
    end

    go_idle();
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
